// ----- sv/hpt_pkg.sv -----
// Shared types and constants for the homogeneous point transform.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;

    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_W    = 2;
    localparam int unsigned QCNT_W    = 3;

    // Register indexes
    localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;

    // Identity matrix after reset
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic                      w_was_zero;
        logic                      saturated;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

// ----- sv/hpt_fifo.sv -----
// Short point queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module hpt_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire hpt_pkg::t_point i_data,
    input  wire logic            i_rd,
    output hpt_pkg::t_point      o_data,
    output hpt_pkg::t_qstat      o_stat
);
    hpt_pkg::t_point                 r_mem [hpt_pkg::QDEPTH];
    logic [hpt_pkg::QPTR_W-1:0]      r_wptr, r_rptr;
    logic [hpt_pkg::QCNT_W-1:0]      r_cnt, n_cnt;
    logic                            w_wr, w_rd;

    assign o_stat.full  = (r_cnt == hpt_pkg::QCNT_W'(hpt_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr = i_wr && !o_stat.full;
    assign w_rd = i_rd && !o_stat.empty;
    assign o_data = r_mem[r_rptr];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Store beat
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/hpt_front.sv -----
// Input stage: accept a point, narrow it to the operand width, hand it to the queue.
`timescale 1ns / 1ps
`default_nettype none
module hpt_front #(
    parameter int unsigned CB = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire hpt_pkg::t_point i_point,
    output logic                 o_full,
    input  wire hpt_pkg::t_qstat i_qstat,
    output logic                 o_qwr,
    output hpt_pkg::t_point      o_qdata
);
    logic            r_valid;
    hpt_pkg::t_point r_item;
    logic            w_acc;

    assign o_full  = r_valid && i_qstat.full;
    assign w_acc   = i_push && !o_full;
    assign o_qwr   = r_valid && !i_qstat.full;
    assign o_qdata = r_item;

    // Hold one beat until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (o_qwr) begin
            r_valid <= 1'b0;
        end
    end

    // Keep only the low operand bits, sign extended
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.point_x <= hpt_pkg::FIELD_W'($signed(i_point.point_x[CB-1:0]));
            r_item.point_y <= hpt_pkg::FIELD_W'($signed(i_point.point_y[CB-1:0]));
            r_item.point_z <= hpt_pkg::FIELD_W'($signed(i_point.point_z[CB-1:0]));
        end
    end
endmodule
`default_nettype wire

// ----- sv/hpt_back.sv -----
// Transform pipeline: products, column sums, magnitudes, restoring divide, clamp.
`timescale 1ns / 1ps
`default_nettype none
module hpt_back #(
    parameter int unsigned CB = 32,
    parameter int unsigned FB = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [hpt_pkg::CFG_W-1:0]  i_regs [hpt_pkg::NUM_REGS],
    input  wire hpt_pkg::t_qstat            i_qstat,
    input  wire hpt_pkg::t_point            i_item,
    output logic                            o_take,
    output hpt_pkg::t_result                o_result,
    output logic                            o_empty,
    input  wire logic                       i_pop
);
    localparam int unsigned PW = 2 * CB;
    localparam int unsigned SW = ((2 * CB > CB + FB) ? 2 * CB : CB + FB) + 3;
    localparam int unsigned MW = SW - 1;
    localparam int unsigned CW = MW + ((FB > CB) ? FB : CB);

    logic adv;
    logic r_out_valid;

    // Whole pipeline moves when the output register frees up
    assign adv      = !r_out_valid || i_pop;
    assign o_take   = adv && !i_qstat.empty;
    assign o_empty  = !r_out_valid;

    // Matrix entries and point operands
    logic signed [CB-1:0] m [4][4];
    logic signed [CB-1:0] p [3];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                m[r][c] = (c % 2 == 1) ? i_regs[r * 2 + c / 2][32 +: CB]
                                       : i_regs[r * 2 + c / 2][0 +: CB];
            end
        end
        p[0] = i_item.point_x[CB-1:0];
        p[1] = i_item.point_y[CB-1:0];
        p[2] = i_item.point_z[CB-1:0];
    end

    // Stage 1: products
    logic                 r1_v;
    logic signed [PW-1:0] r1_prod [4][3];
    logic signed [CB-1:0] r1_tr   [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r1_prod[c][r] <= m[r][c] * p[r];
                end
                r1_tr[c] <= m[3][c];
            end
        end
    end

    // Stage 2: exact column sums
    logic                 r2_v;
    logic signed [SW-1:0] r2_sum [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                r2_sum[c] <= SW'(r1_prod[c][0]) + SW'(r1_prod[c][1]) + SW'(r1_prod[c][2])
                           + (SW'(r1_tr[c]) <<< FB);
            end
        end
    end

    // Stage 3: sign and magnitude
    logic          r3_v;
    logic [MW-1:0] r3_mag [4];
    logic          r3_neg [4];
    logic          r3_wz;
    logic [SW-1:0] w_abs  [4];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_abs[c] = r2_sum[c][SW-1] ? SW'(-r2_sum[c]) : SW'(r2_sum[c]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                r3_mag[c] <= w_abs[c][MW-1:0];
                r3_neg[c] <= r2_sum[c][SW-1];
            end
            r3_wz <= (r2_sum[3] == '0);
        end
    end

    // Divider lanes; index 0 is loaded by the range check, index CB is done
    logic          r_dv_v  [0:CB];
    logic [MW-1:0] r_rem   [0:CB][3];
    logic [CB-1:0] r_q     [0:CB][3];
    logic [CB-1:0] r_nlo   [0:CB][3];
    logic          r_ovf   [0:CB][3];
    logic          r_neg   [0:CB][3];
    logic [MW-1:0] r_d     [0:CB];
    logic          r_wz    [0:CB];

    // Stage 4: quotient range check and first partial remainder
    logic [CW-1:0] w_num [3];
    logic [CW-1:0] w_dsh;
    always_comb begin
        w_dsh = CW'(r3_mag[3]) << CB;
        for (int l = 0; l < 3; l++) begin
            w_num[l] = CW'(r3_mag[l]) << FB;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                r_ovf[0][l] <= (w_num[l] >= w_dsh);
                r_rem[0][l] <= MW'(w_num[l] >> CB);
                r_nlo[0][l] <= w_num[l][CB-1:0];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= r3_neg[l] ^ r3_neg[3];
            end
            r_d[0]  <= r3_mag[3];
            r_wz[0] <= r3_wz;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < CB; k++) begin : g_div
        logic [MW:0] w_t  [3];
        logic        w_ge [3];
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                w_t[l]  = {r_rem[k][l], r_nlo[k][l][CB-1-k]};
                w_ge[l] = (w_t[l] >= {1'b0, r_d[k]});
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[k+1][l] <= w_ge[l] ? MW'(w_t[l] - {1'b0, r_d[k]}) : MW'(w_t[l]);
                    r_q[k+1][l]   <= {r_q[k][l][CB-2:0], w_ge[l]};
                    r_nlo[k+1][l] <= r_nlo[k][l];
                    r_ovf[k+1][l] <= r_ovf[k][l];
                    r_neg[k+1][l] <= r_neg[k][l];
                end
                r_d[k+1]  <= r_d[k];
                r_wz[k+1] <= r_wz[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
    end

    // Clamp, apply sign, zero on degenerate w
    logic [CB-1:0]                 w_lim [3];
    logic                          w_sat [3];
    logic [CB-1:0]                 w_mq  [3];
    logic [hpt_pkg::FIELD_W-1:0]   w_o   [3];
    hpt_pkg::t_result              w_res;
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_lim[l] = r_neg[CB][l] ? (CB'(1) << (CB - 1)) : ((CB'(1) << (CB - 1)) - 1'b1);
            w_sat[l] = r_ovf[CB][l] || (r_q[CB][l] > w_lim[l]);
            w_mq[l]  = w_sat[l] ? w_lim[l] : r_q[CB][l];
            w_o[l]   = r_neg[CB][l] ? hpt_pkg::FIELD_W'(0) - hpt_pkg::FIELD_W'(w_mq[l])
                                    : hpt_pkg::FIELD_W'(w_mq[l]);
        end
        if (r_wz[CB]) begin
            w_res = '0;
            w_res.w_was_zero = 1'b1;
        end else begin
            w_res.out_x      = w_o[0];
            w_res.out_y      = w_o[1];
            w_res.out_z      = w_o[2];
            w_res.w_was_zero = 1'b0;
            w_res.saturated  = w_sat[0] || w_sat[1] || w_sat[2];
        end
    end

    // Valid bits for the front stages and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r_dv_v[0]   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_v        <= !i_qstat.empty;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r_dv_v[0]   <= r3_v;
            r_out_valid <= r_dv_v[CB];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_result <= w_res;
        end
    end
endmodule
`default_nettype wire

// ----- sv/homogeneous_point_transform.sv -----
// Top level: configuration registers, input front, queue and transform pipeline.
//
//  channel   direction  handshake                      payload
//  point     in         push / full                    i_point  (hpt_pkg::t_point)
//  result    out        empty / pop                    o_result (hpt_pkg::t_result)
//  config    in/out     psel penable pwrite pready     paddr pwdata prdata, 64-bit
//
//  One point per cycle sustained while results are popped; a point passes the
//  front register, queue, four arithmetic stages and one restoring-divide stage
//  per quotient bit to reach the result register. Reset is synchronous, active
//  low, and loads the identity matrix. A stalled pop freezes the whole pipeline;
//  the front register and the four-entry queue keep taking points until they fill.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform #(
    parameter int unsigned COORD_BITS    = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire hpt_pkg::t_point             i_point,
    output logic                             empty,
    input  wire logic                        pop,
    output hpt_pkg::t_result                 o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hpt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [hpt_pkg::CFG_W-1:0]   pwdata,
    output logic [hpt_pkg::CFG_W-1:0]        prdata,
    output logic                             pready
);
    logic [hpt_pkg::CFG_W-1:0] r_regs [hpt_pkg::NUM_REGS];
    logic [2:0]                w_idx;
    hpt_pkg::t_qstat           w_qstat;
    hpt_pkg::t_point           w_qin, w_qout;
    logic                      w_qwr, w_take;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];
    assign prdata = r_regs[w_idx];

    // Write a register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
                r_regs[i] <= hpt_pkg::CFG_RESET[i];
            end
        end else if (psel && penable && pwrite && pready) begin
            r_regs[w_idx] <= pwdata;
        end
    end

    hpt_front #(.CB(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (i_point),
        .o_full  (full),
        .i_qstat (w_qstat),
        .o_qwr   (w_qwr),
        .o_qdata (w_qin)
    );

    hpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_qwr),
        .i_data  (w_qin),
        .i_rd    (w_take),
        .o_data  (w_qout),
        .o_stat  (w_qstat)
    );

    hpt_back #(.CB(COORD_BITS), .FB(FRACTION_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_regs   (r_regs),
        .i_qstat  (w_qstat),
        .i_item   (w_qout),
        .o_take   (w_take),
        .o_result (o_result),
        .o_empty  (empty),
        .i_pop    (pop)
    );
endmodule
`default_nettype wire

// ----- sv/hpt_checker.sv -----
// Port-level checks for the point transform, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hpt_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire hpt_pkg::t_result o_result
);
    // Reset drains the result side
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible right after reset");

    // Reset frees the input side
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full right after reset");

    // Degenerate w gives zero coordinates and no clamp
    a_wzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.w_was_zero) |->
        (o_result.out_x == 0 && o_result.out_y == 0 && o_result.out_z == 0
         && !o_result.saturated))
        else $error("zero w with nonzero result");

    // A waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result changed while waiting");
endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
`default_nettype wire
